@@ rtl/core/mme_pkg.sv @@
// Shared types, constants and helpers for the matrix multiply engine.
// Used by mme_controller, mme_datapath and matrix_multiply_engine; depends on nothing.
`default_nettype none

package mme_pkg;

    // default sizing, handed down as parameters from the top level
    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 16;

    // fixed field widths
    localparam int OPCODE_W    = 2;
    localparam int POS_W       = 3;
    localparam int DIM_W       = 4;
    localparam int RESULT_W    = 35;
    localparam int CFG_INDEX_W = 2;

    localparam logic [DIM_W-1:0] CFG_DIM_RESET = DIM_W'(8);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2,
        OP_NOP        = 2'd3
    } mme_opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEFT_ROWS  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_RIGHT_COLS = 2'd2,
        CFG_UNUSED     = 2'd3
    } mme_cfg_index_t;

    // controller to datapath
    typedef struct packed {
        logic             wr_left;
        logic             wr_right;
        logic             rd_valid;
        logic             rd_first;
        logic             rd_last;
        logic [DIM_W-1:0] rd_row;
        logic [DIM_W-1:0] rd_inner;
        logic [DIM_W-1:0] rd_col;
        logic             emit;
        logic             emit_last;
    } mme_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sum_valid;
        logic out_free;
    } mme_status_t;

    // zero counts as one, anything above the cap is held at the cap
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > cap) begin
            r = cap;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/matrix_multiply_engine.sv @@
// Top level of the matrix multiply engine: joins controller and datapath.
// Depends on mme_pkg, mme_controller and mme_datapath.
//
// Left and right elements (signed Q8.8) are loaded one per transfer at row and
// column into two element stores; loads are taken one per cycle. A compute
// transfer then returns left_rows x right_cols results in row-major order, each
// the exact signed Q19.16 dot product over inner_size terms, the final one
// flagged by m_last_result. Each result is built from inner_size store reads on
// one read port per store, then the registered multiply and accumulate stages;
// a stalled result register holds the walk. No input is taken while a compute
// walk runs. Register values of zero count as one and values above MAX_DIM as
// MAX_DIM. Store entries never written read as anything. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
`default_nettype none

module matrix_multiply_engine #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mme_pkg::DATA_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [mme_pkg::OPCODE_W-1:0]         s_opcode,
    input  wire  [mme_pkg::POS_W-1:0]            s_row_index,
    input  wire  [mme_pkg::POS_W-1:0]            s_col_index,
    input  wire  signed [DATA_WIDTH-1:0]         s_element_value,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [mme_pkg::RESULT_W-1:0]  m_product_value,
    output logic [mme_pkg::POS_W-1:0]            m_out_row,
    output logic [mme_pkg::POS_W-1:0]            m_out_col,
    output logic                                 m_last_result,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [mme_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [mme_pkg::DIM_W-1:0]            cfg_data
);

    mme_pkg::mme_cmd_t    cmd;
    mme_pkg::mme_status_t status;

    mme_controller #(
        .MAX_DIM (MAX_DIM)
    ) u_controller (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .cmd         (cmd)
    );

    mme_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_product_value (m_product_value),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_last_result   (m_last_result),
        .status          (status)
    );

endmodule

`default_nettype wire

@@ rtl/core/mme_controller.sv @@
// Sequencer for the matrix multiply engine: configuration registers, input
// handshake and the row/column/inner walk. Depends on mme_pkg.
`default_nettype none

module mme_controller #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [mme_pkg::OPCODE_W-1:0]        s_opcode,
    input  wire  [mme_pkg::POS_W-1:0]           s_row_index,
    input  wire  [mme_pkg::POS_W-1:0]           s_col_index,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [mme_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [mme_pkg::DIM_W-1:0]           cfg_data,
    input  mme_pkg::mme_status_t                status,
    output mme_pkg::mme_cmd_t                   cmd
);

    localparam int DIM_W   = mme_pkg::DIM_W;
    localparam int DIM_CAP = (MAX_DIM < 15) ? MAX_DIM : 15;
    localparam logic [DIM_W-1:0] CAP = DIM_W'(DIM_CAP);
    localparam logic [DIM_W-1:0] ONE = DIM_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] inner_reg, inner_next;
    logic [DIM_W-1:0] nr_reg, nr_next;
    logic [DIM_W-1:0] nk_reg, nk_next;
    logic [DIM_W-1:0] nc_reg, nc_next;
    logic [DIM_W-1:0] left_rows_reg, inner_size_reg, right_cols_reg;

    logic in_accept;
    logic in_range;
    logic at_last_inner;
    logic at_last_col;
    logic at_last_elem;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign in_range  = (32'(s_row_index) < MAX_DIM) && (32'(s_col_index) < MAX_DIM);

    assign at_last_inner = (inner_reg == nk_reg - ONE);
    assign at_last_col   = (col_reg == nc_reg - ONE);
    assign at_last_elem  = (row_reg == nr_reg - ONE) && at_last_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_rows_reg  <= mme_pkg::CFG_DIM_RESET;
            inner_size_reg <= mme_pkg::CFG_DIM_RESET;
            right_cols_reg <= mme_pkg::CFG_DIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                mme_pkg::CFG_LEFT_ROWS:  left_rows_reg  <= cfg_data;
                mme_pkg::CFG_INNER_SIZE: inner_size_reg <= cfg_data;
                mme_pkg::CFG_RIGHT_COLS: right_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.wr_left   = in_accept && (s_opcode == mme_pkg::OP_LOAD_LEFT) && in_range;
        cmd.wr_right  = in_accept && (s_opcode == mme_pkg::OP_LOAD_RIGHT) && in_range;
        cmd.rd_valid  = (state_reg == ST_RUN);
        cmd.rd_first  = (inner_reg == '0);
        cmd.rd_last   = at_last_inner;
        cmd.rd_row    = row_reg;
        cmd.rd_inner  = inner_reg;
        cmd.rd_col    = col_reg;
        cmd.emit      = (state_reg == ST_WAIT) && status.sum_valid && status.out_free;
        cmd.emit_last = at_last_elem;
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        inner_next = inner_reg;
        nr_next    = nr_reg;
        nk_next    = nk_reg;
        nc_next    = nc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_opcode == mme_pkg::OP_COMPUTE)) begin
                    nr_next    = mme_pkg::clamp_dim(left_rows_reg, CAP);
                    nk_next    = mme_pkg::clamp_dim(inner_size_reg, CAP);
                    nc_next    = mme_pkg::clamp_dim(right_cols_reg, CAP);
                    row_next   = '0;
                    col_next   = '0;
                    inner_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (at_last_inner) begin
                    inner_next = '0;
                    state_next = ST_WAIT;
                end else begin
                    inner_next = inner_reg + ONE;
                end
            end
            ST_WAIT: begin
                if (cmd.emit) begin
                    if (at_last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RUN;
                        if (at_last_col) begin
                            col_next = '0;
                            row_next = row_reg + ONE;
                        end else begin
                            col_next = col_reg + ONE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            inner_reg <= '0;
            nr_reg    <= ONE;
            nk_reg    <= ONE;
            nc_reg    <= ONE;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            inner_reg <= inner_next;
            nr_reg    <= nr_next;
            nk_reg    <= nk_next;
            nc_reg    <= nc_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mme_datapath.sv @@
// Datapath of the matrix multiply engine: element stores, multiply-accumulate
// pipeline and result register. Depends on mme_pkg.
`default_nettype none

module mme_datapath #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mme_pkg::DATA_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  mme_pkg::mme_cmd_t                    cmd,
    input  wire  [mme_pkg::POS_W-1:0]            s_row_index,
    input  wire  [mme_pkg::POS_W-1:0]            s_col_index,
    input  wire  signed [DATA_WIDTH-1:0]         s_element_value,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [mme_pkg::RESULT_W-1:0]  m_product_value,
    output logic [mme_pkg::POS_W-1:0]            m_out_row,
    output logic [mme_pkg::POS_W-1:0]            m_out_col,
    output logic                                 m_last_result,
    output mme_pkg::mme_status_t                 status
);

    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W   = 2 * DATA_WIDTH;
    localparam int ACC_W    = PROD_W + mme_pkg::DIM_W;
    localparam int RESULT_W = mme_pkg::RESULT_W;

    logic signed [DATA_WIDTH-1:0] left_mem  [DEPTH];
    logic signed [DATA_WIDTH-1:0] right_mem [DEPTH];

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] left_rd_addr;
    logic [ADDR_W-1:0] right_rd_addr;

    logic signed [DATA_WIDTH-1:0] left_q_reg, right_q_reg;
    logic                         p1_valid_reg, p1_first_reg, p1_last_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic                         p2_valid_reg, p2_first_reg, p2_last_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic                         sum_valid_reg;
    logic signed [RESULT_W-1:0]   sum_ext;

    logic                         out_valid_reg;
    logic signed [RESULT_W-1:0]   out_value_reg;
    logic [mme_pkg::POS_W-1:0]    out_row_reg, out_col_reg;
    logic                         out_last_reg;

    assign wr_addr       = ADDR_W'(32'(s_row_index) * MAX_DIM + 32'(s_col_index));
    assign left_rd_addr  = ADDR_W'(32'(cmd.rd_row) * MAX_DIM + 32'(cmd.rd_inner));
    assign right_rd_addr = ADDR_W'(32'(cmd.rd_inner) * MAX_DIM + 32'(cmd.rd_col));

    always_ff @(posedge aclk) begin
        if (cmd.wr_left) begin
            left_mem[wr_addr] <= s_element_value;
        end
        if (cmd.rd_valid) begin
            left_q_reg <= left_mem[left_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_right) begin
            right_mem[wr_addr] <= s_element_value;
        end
        if (cmd.rd_valid) begin
            right_q_reg <= right_mem[right_rd_addr];
        end
    end

    // first term of a dot product restarts the sum
    always_comb begin
        if (p2_first_reg) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        p1_first_reg <= cmd.rd_first;
        p1_last_reg  <= cmd.rd_last;
        if (p1_valid_reg) begin
            prod_reg     <= left_q_reg * right_q_reg;
            p2_first_reg <= p1_first_reg;
            p2_last_reg  <= p1_last_reg;
        end
        if (p2_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.rd_valid;
            p2_valid_reg <= p1_valid_reg;
            if (p2_valid_reg && p2_last_reg) begin
                sum_valid_reg <= 1'b1;
            end else if (cmd.emit) begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    generate
        if (ACC_W >= RESULT_W) begin : g_trunc
            assign sum_ext = acc_reg[RESULT_W-1:0];
        end else begin : g_sext
            assign sum_ext = {{(RESULT_W - ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_value_reg <= sum_ext;
            out_row_reg   <= cmd.rd_row[mme_pkg::POS_W-1:0];
            out_col_reg   <= cmd.rd_col[mme_pkg::POS_W-1:0];
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign status.sum_valid = sum_valid_reg;
    assign status.out_free  = !out_valid_reg || m_ready;

    assign m_valid         = out_valid_reg;
    assign m_product_value = out_value_reg;
    assign m_out_row       = out_row_reg;
    assign m_out_col       = out_col_reg;
    assign m_last_result   = out_last_reg;

endmodule

`default_nettype wire

@@ verif/mme_result_checker.sv @@
// Result checker for the matrix multiply engine: watches the load, result and register channels.
// Keeps its own element stores and sizes, predicts every product element and compares each transfer.
// Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_result_checker (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    input  wire                                  s_ready,
    input  wire  [mme_pkg::OPCODE_W-1:0]         s_opcode,
    input  wire  [mme_pkg::POS_W-1:0]            s_row_index,
    input  wire  [mme_pkg::POS_W-1:0]            s_col_index,
    input  wire  signed [mme_pkg::DATA_WIDTH_DEF-1:0] s_element_value,
    input  wire                                  m_valid,
    input  wire                                  m_ready,
    input  wire  signed [mme_pkg::RESULT_W-1:0]  m_product_value,
    input  wire  [mme_pkg::POS_W-1:0]            m_out_row,
    input  wire  [mme_pkg::POS_W-1:0]            m_out_col,
    input  wire                                  m_last_result,
    input  wire                                  cfg_valid,
    input  wire                                  cfg_ready,
    input  wire  [mme_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [mme_pkg::DIM_W-1:0]            cfg_data,
    output int                                   mismatch_count,
    output int                                   pending_count,
    output int                                   products_checked
);
    import mme_pkg::*;

    localparam int DIM_CAP = MAX_DIM_DEF;
    localparam int ELEM_W  = DATA_WIDTH_DEF;

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic                last;
    } product_t;

    logic signed [ELEM_W-1:0] left_elems  [0:DIM_CAP*DIM_CAP-1];
    logic signed [ELEM_W-1:0] right_elems [0:DIM_CAP*DIM_CAP-1];
    logic [DIM_W-1:0] rows_reg  = CFG_DIM_RESET;
    logic [DIM_W-1:0] inner_reg = CFG_DIM_RESET;
    logic [DIM_W-1:0] cols_reg  = CFG_DIM_RESET;

    product_t product_q[$];
    int       errors  = 0;
    int       checked = 0;

    initial begin
        mismatch_count   = 0;
        pending_count    = 0;
        products_checked = 0;
    end

    // zero is taken as one, anything past the store size as the store size
    function automatic int used_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > DIM_CAP) return DIM_CAP;
        return int'(v);
    endfunction

    always @(posedge aclk) begin : predict
        product_t want;
        product_t entry;
        longint   acc;
        int       n_rows;
        int       n_inner;
        int       n_cols;

        if (aresetn) begin
            // results first: a result transfer on the same edge as an input is older
            if (m_valid && m_ready) begin
                checked++;
                if (product_q.size() == 0) begin
                    $error("result transfer with nothing expected: row %0d col %0d value %0d",
                           m_out_row, m_out_col, m_product_value);
                    errors++;
                end else begin
                    want = product_q.pop_front();
                    if (m_product_value !== want.value) begin
                        $error("product_value expected %0d actual %0d",
                               $signed(want.value), m_product_value);
                        errors++;
                    end
                    if (m_out_row !== want.row) begin
                        $error("out_row expected %0d actual %0d", want.row, m_out_row);
                        errors++;
                    end
                    if (m_out_col !== want.col) begin
                        $error("out_col expected %0d actual %0d", want.col, m_out_col);
                        errors++;
                    end
                    if (m_last_result !== want.last) begin
                        $error("last_result expected %0d actual %0d", want.last, m_last_result);
                        errors++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (mme_cfg_index_t'(cfg_index))
                    CFG_LEFT_ROWS:  rows_reg  = cfg_data;
                    CFG_INNER_SIZE: inner_reg = cfg_data;
                    CFG_RIGHT_COLS: cols_reg  = cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                case (mme_opcode_t'(s_opcode))
                    OP_LOAD_LEFT:
                        left_elems[s_row_index * DIM_CAP + s_col_index] = s_element_value;
                    OP_LOAD_RIGHT:
                        right_elems[s_row_index * DIM_CAP + s_col_index] = s_element_value;
                    OP_COMPUTE: begin
                        n_rows  = used_dim(rows_reg);
                        n_inner = used_dim(inner_reg);
                        n_cols  = used_dim(cols_reg);
                        for (int i = 0; i < n_rows; i++) begin
                            for (int k = 0; k < n_cols; k++) begin
                                acc = 0;
                                for (int j = 0; j < n_inner; j++) begin
                                    acc += longint'(left_elems[i * DIM_CAP + j]) *
                                           longint'(right_elems[j * DIM_CAP + k]);
                                end
                                entry.value = acc[RESULT_W-1:0];
                                entry.row   = i[POS_W-1:0];
                                entry.col   = k[POS_W-1:0];
                                entry.last  = (i == n_rows - 1) && (k == n_cols - 1);
                                // append at the tail so results come out in walk order
                                product_q.insert(product_q.size(), entry);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        mismatch_count   <= errors;
        pending_count    <= product_q.size();
        products_checked <= checked;
    end

endmodule

@@ verif/tb_matrix_multiply_engine.sv @@
// Top of the matrix multiply engine testbench: clock, reset, load and register stimulus, verdict.
// Depends on mme_pkg, matrix_multiply_engine and mme_result_checker.
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
    import mme_pkg::*;

    localparam int DIM_CAP         = MAX_DIM_DEF;
    localparam int ELEM_W          = DATA_WIDTH_DEF;
    localparam int ITEM_TARGET     = 210;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic aclk;
    logic aresetn = 1'b0;

    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic [OPCODE_W-1:0]      s_opcode        = '0;
    logic [POS_W-1:0]         s_row_index     = '0;
    logic [POS_W-1:0]         s_col_index     = '0;
    logic signed [ELEM_W-1:0] s_element_value = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic signed [RESULT_W-1:0] m_product_value;
    logic [POS_W-1:0]         m_out_row;
    logic [POS_W-1:0]         m_out_col;
    logic                     m_last_result;
    logic                     cfg_valid       = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index       = '0;
    logic [DIM_W-1:0]         cfg_data        = '0;

    int  mismatch_count;
    int  pending_count;
    int  products_checked;

    logic hold_off = 1'b0;
    int   items_sent    = 0;
    int   walks_sent    = 0;
    int   reg_writes    = 0;
    int   burst_left    = 0;
    int   idle_cycles   = 0;
    bit   left_written  [0:DIM_CAP*DIM_CAP-1];
    bit   right_written [0:DIM_CAP*DIM_CAP-1];
    logic [DIM_W-1:0] rows_set  = CFG_DIM_RESET;
    logic [DIM_W-1:0] inner_set = CFG_DIM_RESET;
    logic [DIM_W-1:0] cols_set  = CFG_DIM_RESET;

    matrix_multiply_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_product_value (m_product_value),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_last_result   (m_last_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    mme_result_checker product_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_row_index      (s_row_index),
        .s_col_index      (s_col_index),
        .s_element_value  (s_element_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_product_value  (m_product_value),
        .m_out_row        (m_out_row),
        .m_out_col        (m_out_col),
        .m_last_result    (m_last_result),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count),
        .products_checked (products_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ends the run if no channel moves a transfer for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_count);
            $display("matrix_multiply_engine verification failed");
            $finish;
        end
    end

    // result side: windows of differing stall density, plus one long hold-off on request
    initial begin : receiver
        int  stall_mode;
        int  window;
        bit  held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            stall_mode = $urandom_range(0, 3);
            window     = $urandom_range(8, 64);
            repeat (window) begin
                @(posedge aclk);
                if (hold_off && !held) begin
                    m_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                    held = 1'b1;
                end
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    function automatic logic signed [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return -16'sd1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'(DIM_CAP);
            2:       return DIM_W'($urandom_range(DIM_CAP + 1, 15));
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    // one load, compute or no-op transfer; the sender runs in bursts with gaps between them
    task automatic send_item(input mme_opcode_t op, input logic [POS_W-1:0] row,
                             input logic [POS_W-1:0] col,
                             input logic signed [ELEM_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_row_index     <= row;
        s_col_index     <= col;
        s_element_value <= value;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        case (op)
            OP_LOAD_LEFT:  left_written[row * DIM_CAP + col] = 1'b1;
            OP_LOAD_RIGHT: right_written[row * DIM_CAP + col] = 1'b1;
            OP_COMPUTE:    walks_sent++;
            default: ;
        endcase
        if (op != OP_NOP) items_sent++;
    endtask

    // every element the next walk reads must have been loaded
    task automatic fill_operands();
        int nr;
        int nk;
        int nc;
        nr = int'(clamp_dim(rows_set, DIM_W'(DIM_CAP)));
        nk = int'(clamp_dim(inner_set, DIM_W'(DIM_CAP)));
        nc = int'(clamp_dim(cols_set, DIM_W'(DIM_CAP)));
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nk; j++) begin
                if (!left_written[i * DIM_CAP + j])
                    send_item(OP_LOAD_LEFT, POS_W'(i), POS_W'(j), rand_element());
            end
        end
        for (int j = 0; j < nk; j++) begin
            for (int k = 0; k < nc; k++) begin
                if (!right_written[j * DIM_CAP + k])
                    send_item(OP_LOAD_RIGHT, POS_W'(j), POS_W'(k), rand_element());
            end
        end
    endtask

    task automatic send_walk();
        fill_operands();
        send_item(OP_COMPUTE, POS_W'($urandom), POS_W'($urandom), rand_element());
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        // loads and no-ops leave nothing to wait for, so give the pipeline time to empty
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // cfg_valid stays high between back-to-back register transfers
    task automatic write_reg(input mme_cfg_index_t idx, input logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LEFT_ROWS:  rows_set  = value;
            CFG_INNER_SIZE: inner_set = value;
            CFG_RIGHT_COLS: cols_set  = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                             input logic [DIM_W-1:0] cols, input bit poke_unused);
        wait_idle();
        write_reg(CFG_LEFT_ROWS, rows);
        write_reg(CFG_INNER_SIZE, inner);
        write_reg(CFG_RIGHT_COLS, cols);
        if (poke_unused) write_reg(CFG_UNUSED, DIM_W'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int          nr;
        int          nk;
        int          nc;
        int          pick;
        int          run_len;
        bit          squeezed;
        mme_opcode_t op;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;

        squeezed = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // full-scale dot product: eight most-negative pairs give the largest sum
        configure(4'd1, 4'd8, 4'd1, 1'b0);
        send_item(OP_NOP, 3'd7, 3'd7, 16'sh7fff);
        for (int j = 0; j < DIM_CAP; j++) send_item(OP_LOAD_LEFT, 3'd0, POS_W'(j), 16'sh8000);
        for (int j = 0; j < DIM_CAP; j++) send_item(OP_LOAD_RIGHT, POS_W'(j), 3'd0, 16'sh8000);
        send_item(OP_COMPUTE, 3'd0, 3'd0, '0);
        send_item(OP_LOAD_LEFT, 3'd0, 3'd7, 16'sh7fff);
        send_item(OP_COMPUTE, 3'd7, 3'd7, 16'sh8000);
        send_item(OP_LOAD_LEFT, 3'd7, 3'd7, 16'sh7fff);
        send_item(OP_LOAD_RIGHT, 3'd7, 3'd7, -16'sd1);
        // zero sizes count as one
        configure(4'd0, 4'd0, 4'd0, 1'b1);
        send_item(OP_COMPUTE, 3'd5, 3'd2, 16'sh1234);

        while (items_sent < ITEM_TARGET) begin
            configure(pick_dim(), pick_dim(), pick_dim(), $urandom_range(0, 7) == 0);
            nr = int'(clamp_dim(rows_set, DIM_W'(DIM_CAP)));
            nk = int'(clamp_dim(inner_set, DIM_W'(DIM_CAP)));
            nc = int'(clamp_dim(cols_set, DIM_W'(DIM_CAP)));
            run_len = $urandom_range(4, 14);
            repeat (run_len) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_item(OP_NOP, POS_W'($urandom), POS_W'($urandom), rand_element());
                end else if (pick < 4) begin
                    send_walk();
                end else begin
                    op = pick[0] ? OP_LOAD_LEFT : OP_LOAD_RIGHT;
                    if ($urandom_range(0, 9) < 7) begin
                        row = POS_W'($urandom_range(0, (op == OP_LOAD_LEFT ? nr : nk) - 1));
                        col = POS_W'($urandom_range(0, (op == OP_LOAD_LEFT ? nk : nc) - 1));
                    end else begin
                        row = POS_W'($urandom);
                        col = POS_W'($urandom);
                    end
                    send_item(op, row, col, rand_element());
                end
            end
            send_walk();

            // widest result matrix while the result side holds off and loads keep coming
            if (!squeezed && items_sent > 90) begin
                squeezed = 1'b1;
                configure(4'd15, 4'd1, 4'd8, 1'b1);
                send_walk();
                hold_off <= 1'b1;
                repeat (10) begin
                    send_item($urandom_range(0, 1) ? OP_LOAD_LEFT : OP_LOAD_RIGHT,
                              POS_W'($urandom), POS_W'($urandom), rand_element());
                end
                send_walk();
            end
        end

        wait_idle();
        repeat (32) @(posedge aclk);
        $display("run covered %0d load/compute transfers, %0d compute walks, %0d register writes",
                 items_sent, walks_sent, reg_writes);
        $display("%0d result transfers checked, %0d mismatches", products_checked,
                 mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("matrix_multiply_engine verification clean");
        end else begin
            $display("matrix_multiply_engine verification failed");
        end
        $finish;
    end

endmodule
